### design/bht_pkg.sv
// Shared types, operation and status codes, and hash helpers for the bucketed hash table.
// Used by bht_hash, the top level and the checker; depends on nothing else.
package bht_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_HIT     = 3'd3;
  localparam logic [2:0] ST_MISS    = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [31:0] write_value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [8:0]  stored_count;
  } out_beat_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_MIX,
    H_FINAL,
    H_DIV,
    H_MOD
  } hash_state_e;

  typedef enum logic [1:0] {
    T_CLEAR,
    T_IDLE,
    T_HASH,
    T_LOOK
  } tbl_state_e;

  // One byte of the one-at-a-time mixing step.
  function automatic logic [31:0] oaat_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [31:0] oaat_final(input logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

### design/bht_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing; every table memory is an instance of this module.
module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic                                     we_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bht_hash.sv
// Multi-cycle hash unit: one-at-a-time hash, two key bytes a cycle, then hash modulo BUCKETS
// through a reciprocal multiply and a remainder stage. Depends on bht_pkg.
module bht_hash import bht_pkg::*; #(
  parameter int BUCKETS   = 64,
  parameter int KEY_BYTES = 8
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [63:0]                                  key_i,
  output logic                                         done_o,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket_o
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int L = $clog2(BUCKETS);
  localparam int SH = 32 + L;
  // Exact quotient for any 32-bit numerator: floor(2^(32+L)/BUCKETS) + 1, at most 33 bits.
  localparam logic [32:0] MAGIC = 33'(((64'd1 << SH) / 64'(BUCKETS)) + 64'd1);
  localparam int NPAIR = (KEY_BYTES + 1) / 2;
  localparam logic [1:0] PAIR_LAST = 2'(NPAIR - 1);
  localparam bit KEY_ODD = (KEY_BYTES % 2) == 1;

  hash_state_e state_q, state_d;
  logic [31:0] h_q, h_d;
  logic [63:0] key_q, key_d;
  logic [1:0] pair_q, pair_d;
  logic [31:0] quo_q, quo_d;
  logic [BW-1:0] bucket_q, bucket_d;
  logic done_q, done_d;

  logic [64:0] prod;
  logic [31:0] rem;
  logic [31:0] mix;

  always_comb begin
    state_d = state_q;
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          state_d = H_MIX;
        end
      end
      H_MIX: begin
        if (pair_q == PAIR_LAST) begin
          state_d = H_FINAL;
        end
      end
      H_FINAL: state_d = H_DIV;
      H_DIV:   state_d = H_MOD;
      H_MOD:   state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  assign prod = 65'(h_q) * 65'(MAGIC);
  assign rem = h_q - 32'(quo_q * 32'(BUCKETS));

  always_comb begin
    // The second byte of the last pair is absent when the key has an odd byte count.
    mix = oaat_mix(h_q, key_q[7:0]);
    if (!((pair_q == PAIR_LAST) && KEY_ODD)) begin
      mix = oaat_mix(mix, key_q[15:8]);
    end
  end

  always_comb begin
    h_d = h_q;
    key_d = key_q;
    pair_d = pair_q;
    quo_d = quo_q;
    bucket_d = bucket_q;
    done_d = 1'b0;
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          h_d = '0;
          key_d = key_i;
          pair_d = '0;
        end
      end
      H_MIX: begin
        h_d = mix;
        key_d = key_q >> 16;
        pair_d = pair_q + 2'd1;
      end
      H_FINAL: h_d = oaat_final(h_q);
      H_DIV:   quo_d = 32'(prod >> SH);
      H_MOD: begin
        bucket_d = rem[BW-1:0];
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q <= 1'b0;
      pair_q <= '0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
      pair_q <= pair_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    key_q <= key_d;
    quo_q <= quo_d;
    bucket_q <= bucket_d;
  end

  assign done_o = done_q;
  assign bucket_o = bucket_q;

endmodule

### design/bucketed_hash_table_unit.sv
// Top level of the bucketed hash table: request sequencer, bucket row memory, slot match logic.
// Depends on bht_pkg, bht_hash and bht_ram.
//
//   Channel | Direction | Handshake                | Beat type
//   in      | input     | in_valid_i / in_stall_o  | in_beat_t  (func, key, write_value)
//   out     | output    | out_valid_o / out_stall_i| out_beat_t (status, read_value, stored_count)
//
// One request at a time: the hash unit, the row read and the match logic lie between the
// accepting edge and the registered result beat, which an output stall can hold back; the next
// request can be accepted once the result is registered. The hash unit mixes two bytes a cycle,
// then finalizes, divides and reduces; the bucket row then takes a memory read and a write-back.
// After reset all BUCKETS bucket rows are cleared, one row a cycle, with in_stall_o high.
// A result beat waits in the output register; a new request is accepted while it waits, and
// the write-back of the following request holds until the output register is free.
module bucketed_hash_table_unit import bht_pkg::*; #(
  parameter int BUCKETS     = 64,
  parameter int SLOTS       = 4,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BYTES = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int VAL_W = 8 * ((VALUE_BYTES > 4) ? 4 : VALUE_BYTES);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(BUCKETS * SLOTS + 1);
  localparam int ROW_W = SLOTS * (1 + KEY_W + VAL_W);

  typedef struct packed {
    logic [SLOTS-1:0][VAL_W-1:0] val;
    logic [SLOTS-1:0][KEY_W-1:0] key;
    logic [SLOTS-1:0]            vld;
  } row_t;

  tbl_state_e state_q, state_d;
  logic [BW-1:0] clr_q, clr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  out_beat_t out_data_q, out_data_d;
  logic [1:0] func_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] wval_q;

  logic in_accept;
  logic out_free;
  logic hash_done;
  logic [BW-1:0] bucket;

  logic [BW-1:0] ram_addr;
  logic ram_we;
  logic ram_re;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  row_t row;
  row_t wrow;
  logic found_m, found_f;
  logic [SW-1:0] m_idx, f_idx;
  logic do_write;
  logic [2:0] status;
  logic [VAL_W-1:0] rval;
  logic [CNT_W-1:0] cnt_next;
  logic [31:0] cnt_wide;
  out_beat_t res;

  assign in_accept = in_valid_i && (state_q == T_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  bht_hash #(
    .BUCKETS  (BUCKETS),
    .KEY_BYTES(KEY_BYTES)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .key_i   (64'(in_data_i.key[KEY_W-1:0])),
    .done_o  (hash_done),
    .bucket_o(bucket)
  );

  bht_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BUCKETS)
  ) u_rows (
    .clk_i  (clk_i),
    .addr_i (ram_addr),
    .we_i   (ram_we),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .rdata_o(ram_rdata)
  );

  // Slot search over the bucket row just read: first matching key and first free slot.
  always_comb begin
    row = row_t'(ram_rdata);
    found_m = 1'b0;
    found_f = 1'b0;
    m_idx = '0;
    f_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (row.vld[s]) begin
        if (!found_m && (row.key[s] == key_q)) begin
          found_m = 1'b1;
          m_idx = SW'(s);
        end
      end else if (!found_f) begin
        found_f = 1'b1;
        f_idx = SW'(s);
      end
    end
  end

  always_comb begin
    wrow = row;
    do_write = 1'b0;
    status = ST_MISS;
    rval = '0;
    cnt_next = cnt_q;
    case (func_q)
      FUNC_INSERT: begin
        if (found_m) begin
          wrow.val[m_idx] = wval_q;
          do_write = 1'b1;
          status = ST_UPDATED;
        end else if (found_f) begin
          wrow.val[f_idx] = wval_q;
          wrow.key[f_idx] = key_q;
          wrow.vld[f_idx] = 1'b1;
          do_write = 1'b1;
          cnt_next = cnt_q + CNT_W'(1);
          status = ST_NEW;
        end else begin
          status = ST_FULL;
        end
      end
      FUNC_LOOKUP: begin
        if (found_m) begin
          rval = row.val[m_idx];
          status = ST_HIT;
        end
      end
      FUNC_REMOVE: begin
        if (found_m) begin
          rval = row.val[m_idx];
          wrow.vld[m_idx] = 1'b0;
          do_write = 1'b1;
          cnt_next = cnt_q - CNT_W'(1);
          status = ST_HIT;
        end
      end
      default: ;
    endcase
    cnt_wide = 32'(cnt_next);
    res.status = status;
    res.read_value = 32'(rval);
    res.stored_count = cnt_wide[8:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      T_CLEAR: begin
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = T_IDLE;
        end
      end
      T_IDLE: begin
        if (in_accept) begin
          state_d = T_HASH;
        end
      end
      T_HASH: begin
        if (hash_done) begin
          state_d = T_LOOK;
        end
      end
      T_LOOK: begin
        if (out_free) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  // State outputs: memory port, input stall, counters and result register.
  always_comb begin
    ram_addr = bucket;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_wdata = wrow;
    in_stall_o = (state_q != T_IDLE);
    clr_d = clr_q;
    cnt_d = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d = out_data_q;
    case (state_q)
      T_CLEAR: begin
        ram_addr = clr_q;
        ram_we = 1'b1;
        ram_wdata = '0;
        clr_d = clr_q + BW'(1);
      end
      T_IDLE: ;
      T_HASH: ram_re = hash_done;
      T_LOOK: begin
        // The row is written back only in the cycle the result enters the output register.
        if (out_free) begin
          ram_we = do_write;
          cnt_d = cnt_next;
          out_valid_d = 1'b1;
          out_data_d = res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_CLEAR;
      clr_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_accept) begin
      func_q <= in_data_i.func;
      key_q <= in_data_i.key[KEY_W-1:0];
      wval_q <= in_data_i.write_value[VAL_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule

### design/bht_checker.sv
// Port-level checks for the bucketed hash table, attached to the top level by bind.
// Depends on bht_pkg and bucketed_hash_table_unit.
module bht_checker import bht_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Requests are served one at a time, so the beat after an accepted one is stalled.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted while one is in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_NEW) || (out_data_o.status == ST_UPDATED) ||
                    (out_data_o.status == ST_FULL) || (out_data_o.status == ST_HIT) ||
                    (out_data_o.status == ST_MISS))
    else $error("undefined status code");

  // Only a hit carries a value back.
  a_value_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_HIT) |-> out_data_o.read_value == 32'd0)
    else $error("nonzero read value without a hit");

endmodule

bind bucketed_hash_table_unit bht_checker u_bht_checker (.*);
